// ===== hw/rtl/gnt_pkg.sv =====
// Shared types and constants of the greedy neighbor table.
// Used by the interfaces, the slot memory, the scan datapath and the top level.
package gnt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned POS_W           = 20;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned LIFE_W          = 16;
	localparam int unsigned SQ_W            = 40;
	localparam int unsigned DIST_W          = 41;
	localparam int unsigned PADDR_W         = 3;
	localparam int unsigned PDATA_W         = 32;

	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd2000;

	typedef enum logic [2:0] {
		K_ADD    = 3'd0,
		K_DELETE = 3'd1,
		K_CLEAR  = 3'd2,
		K_QUERY  = 3'd3,
		K_LOOKUP = 3'd4
	} kind_e;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_FULL     = 3'd1,
		ST_HOP      = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_LOCALMIN = 3'd4,
		ST_PRESENT  = 3'd5,
		ST_ABSENT   = 3'd6
	} status_e;

	// Register index, taken from paddr above the byte offset.
	localparam logic REG_LIFETIME = 1'b0;

	typedef struct packed {
		logic [ADDR_W-1:0]       address;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TIME_W-1:0]       stamp;
	} slot_t;

	typedef struct packed {
		logic start;
		logic rd_en;
		logic last;
	} scan_ctl_t;

	typedef struct packed {
		logic              done;
		logic              match;
		logic              free;
		logic              any;
		logic [DIST_W-1:0] best_dist;
		logic [ADDR_W-1:0] best_addr;
		logic [DIST_W-1:0] own_dist;
	} scan_sum_t;

endpackage

// ===== hw/rtl/gnt_if.sv =====
// Request and result channels of the greedy neighbor table.
// Depends on gnt_pkg for field widths.
interface gnt_req_if import gnt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              kind;
	logic [ADDR_W-1:0]       entry_address;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] own_x;
	logic signed [POS_W-1:0] own_y;
	logic [TIME_W-1:0]       now_ms;

	modport source (output valid, kind, entry_address, pos_x, pos_y, own_x, own_y, now_ms,
		input ready);
	modport sink (input valid, kind, entry_address, pos_x, pos_y, own_x, own_y, now_ms,
		output ready);
endinterface

interface gnt_rsp_if import gnt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [ADDR_W-1:0] next_hop;

	modport source (output valid, status, next_hop, input ready);
	modport sink (input valid, status, next_hop, output ready);
endinterface

// ===== hw/rtl/gnt_slot_mem.sv =====
// Slot payload memory: address, position and stamp of each neighbor.
// One write port, one read port with registered read data. Depends on gnt_pkg.
module gnt_slot_mem import gnt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  slot_t            wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output slot_t            rd_data
);

	slot_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

// ===== hw/rtl/gnt_scan.sv =====
// Scan datapath: match and free-slot search, expiry and nearest-neighbor
// selection over a three-stage pipeline fed by the slot memory. Depends on gnt_pkg.
module gnt_scan import gnt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_ctl_t               ctl,
	input  logic [IDX_W-1:0]        rd_idx,
	input  logic [2:0]              kind,
	input  logic [ADDR_W-1:0]       address,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] own_x,
	input  logic signed [POS_W-1:0] own_y,
	input  logic [TIME_W-1:0]       now_ms,
	input  logic [LIFE_W-1:0]       lifetime,
	input  slot_t                   rd_data,
	input  logic [TABLE_DEPTH-1:0]  slot_valid,
	output logic                    expire_en,
	output logic [IDX_W-1:0]        expire_idx,
	output scan_sum_t               sum,
	output logic [IDX_W-1:0]        match_idx,
	output logic [IDX_W-1:0]        free_idx
);

	logic                    vld_s1, last_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    keep_s2, last_s2;
	logic signed [POS_W:0]   dx_s2, dy_s2;
	logic [ADDR_W-1:0]       addr_s2;
	logic                    keep_s3, last_s3;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic [ADDR_W-1:0]       addr_s3;

	logic                    live, hit, expired, keep;
	logic [TIME_W-1:0]       elapsed;
	logic signed [2*POS_W+1:0] prod_x, prod_y, own_prod_x, own_prod_y;
	logic [DIST_W-1:0]       cand_dist;
	logic                    better;

	logic                    match_q, free_q, any_q;
	logic [DIST_W-1:0]       best_dist_q;
	logic [ADDR_W-1:0]       best_addr_q;
	logic [IDX_W-1:0]        match_idx_q, free_idx_q;
	logic signed [POS_W:0]   odx_q, ody_q;
	logic [SQ_W-1:0]         osqx_q, osqy_q;
	logic [DIST_W-1:0]       own_dist_q;

	// Stage 1: the slot read issued last cycle is on rd_data.
	always_comb begin
		live      = vld_s1 && slot_valid[idx_s1];
		hit       = live && (rd_data.address == address);
		elapsed   = now_ms - rd_data.stamp;
		expired   = elapsed >= TIME_W'(lifetime);
		expire_en = live && (kind == K_QUERY) && expired;
		keep      = live && !expired;
	end
	assign expire_idx = idx_s1;

	assign prod_x     = dx_s2 * dx_s2;
	assign prod_y     = dy_s2 * dy_s2;
	assign own_prod_x = odx_q * odx_q;
	assign own_prod_y = ody_q * ody_q;

	// Stage 3: compare against the running best, lower address wins a tie.
	always_comb begin
		cand_dist = DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
		better    = !any_q || (cand_dist < best_dist_q)
			|| ((cand_dist == best_dist_q) && (addr_s3 < best_addr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			keep_s2 <= 1'b0;
			last_s2 <= 1'b0;
			keep_s3 <= 1'b0;
			last_s3 <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			vld_s1  <= ctl.rd_en;
			last_s1 <= ctl.rd_en && ctl.last;
			keep_s2 <= keep;
			last_s2 <= last_s1;
			keep_s3 <= keep_s2;
			last_s3 <= last_s2;
			if (ctl.start) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				any_q   <= 1'b0;
			end else begin
				if (hit && !match_q) begin
					match_q <= 1'b1;
				end
				if (vld_s1 && !slot_valid[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
				if (keep_s3 && better) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx;
		dx_s2   <= (POS_W+1)'(rd_data.x) - (POS_W+1)'(pos_x);
		dy_s2   <= (POS_W+1)'(rd_data.y) - (POS_W+1)'(pos_y);
		addr_s2 <= rd_data.address;
		sqx_s3  <= prod_x[SQ_W-1:0];
		sqy_s3  <= prod_y[SQ_W-1:0];
		addr_s3 <= addr_s2;
		if (hit && !match_q) begin
			match_idx_q <= idx_s1;
		end
		if (vld_s1 && !slot_valid[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (keep_s3 && better) begin
			best_dist_q <= cand_dist;
			best_addr_q <= addr_s3;
		end
		// The node's own distance follows the held request; it settles
		// long before the scan ends.
		odx_q      <= (POS_W+1)'(own_x) - (POS_W+1)'(pos_x);
		ody_q      <= (POS_W+1)'(own_y) - (POS_W+1)'(pos_y);
		osqx_q     <= own_prod_x[SQ_W-1:0];
		osqy_q     <= own_prod_y[SQ_W-1:0];
		own_dist_q <= DIST_W'(osqx_q) + DIST_W'(osqy_q);
	end

	always_comb begin
		sum.done      = last_s3;
		sum.match     = match_q;
		sum.free      = free_q;
		sum.any       = any_q;
		sum.best_dist = best_dist_q;
		sum.best_addr = best_addr_q;
		sum.own_dist  = own_dist_q;
	end
	assign match_idx = match_idx_q;
	assign free_idx  = free_idx_q;

endmodule

// ===== hw/rtl/greedy_neighbor_table.sv =====
// Greedy neighbor table: one request at a time. Clear and unused kinds go from acceptance
// straight to the finish state; add, delete, query and lookup first scan every slot with
// one slot memory read per cycle feeding a 3-stage compare, then finish and load the result.
// A new request is taken the cycle after the previous result is registered.
// Reset (arst_n, asynchronous) clears all slot valid bits and sets the lifetime register to 2000.
module greedy_neighbor_table import gnt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	gnt_req_if.sink            req,
	gnt_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

	// The sequencer walks idle -> scan -> finish; clear and unused kinds skip scan.
	// Scan issues one slot read per cycle and waits for the pipeline to drain;
	// finish commits an add or a delete and loads the result register.
	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [LIFE_W-1:0]       lifetime_q;
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    issuing_q;

	// Held request fields.
	logic [2:0]              kind_q;
	logic [ADDR_W-1:0]       addr_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, own_x_q, own_y_q;
	logic [TIME_W-1:0]       now_q;

	// Result register.
	logic                    rsp_valid_q;
	logic [2:0]              status_q;
	logic [ADDR_W-1:0]       hop_q;

	logic                    accept, fin_go, cfg_wr, last_idx;
	scan_ctl_t               ctl;
	scan_sum_t               sum;
	slot_t                   rd_data, wr_data;
	logic                    expire_en;
	logic [IDX_W-1:0]        expire_idx, match_idx, free_idx;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_idx;
	status_e                 fin_status;
	logic [ADDR_W-1:0]       fin_hop;
	logic                    del_en;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign last_idx  = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

	// Configuration port: zero wait states, single register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_LIFETIME) ? PDATA_W'(lifetime_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_wr && (paddr[2] == REG_LIFETIME)) begin
			lifetime_q <= pwdata[LIFE_W-1:0];
		end
	end

	always_comb begin
		ctl.start = accept;
		ctl.rd_en = (state_q == S_SCAN) && issuing_q;
		ctl.last  = last_idx;
	end

	// Finish: decide the result and the add or delete table update of this request.
	// Adds reuse a matching slot first, else the lowest free slot.
	always_comb begin
		fin_status = ST_DONE;
		fin_hop    = '0;
		wr_en      = 1'b0;
		wr_idx     = match_idx;
		del_en     = 1'b0;
		case (kind_q)
			K_ADD: begin
				if (sum.match) begin
					wr_en = 1'b1;
				end else if (sum.free) begin
					wr_en  = 1'b1;
					wr_idx = free_idx;
				end else begin
					fin_status = ST_FULL;
				end
			end
			K_DELETE: begin
				del_en = sum.match;
			end
			K_QUERY: begin
				if (!sum.any) begin
					fin_status = ST_EMPTY;
				end else if (sum.own_dist > sum.best_dist) begin
					fin_status = ST_HOP;
					fin_hop    = sum.best_addr;
				end else begin
					fin_status = ST_LOCALMIN;
				end
			end
			K_LOOKUP: begin
				fin_status = sum.match ? ST_PRESENT : ST_ABSENT;
			end
			default: begin
				fin_status = ST_DONE;
			end
		endcase
	end

	assign fin_go = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		wr_data.address = addr_q;
		wr_data.x       = pos_x_q;
		wr_data.y       = pos_y_q;
		wr_data.stamp   = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			issuing_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && !fin_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.kind inside {K_ADD, K_DELETE, K_QUERY, K_LOOKUP}) begin
							issuing_q <= 1'b1;
							state_q   <= S_SCAN;
						end else begin
							if (req.kind == K_CLEAR) begin
								valid_q <= '0;
							end
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (issuing_q) begin
						if (last_idx) begin
							issuing_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					// Queries retire stale slots as the scan passes them.
					if (expire_en) begin
						valid_q[expire_idx] <= 1'b0;
					end
					if (sum.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						rsp_valid_q <= 1'b1;
						if (wr_en) begin
							valid_q[wr_idx] <= 1'b1;
						end
						if (del_en) begin
							valid_q[match_idx] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			addr_q  <= req.entry_address;
			pos_x_q <= req.pos_x;
			pos_y_q <= req.pos_y;
			own_x_q <= req.own_x;
			own_y_q <= req.own_y;
			now_q   <= req.now_ms;
		end
		if (fin_go) begin
			status_q <= fin_status;
			hop_q    <= fin_hop;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.next_hop = hop_q;

	gnt_slot_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (fin_go && wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_idx  (cnt_q),
		.rd_data (rd_data)
	);

	gnt_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_idx     (cnt_q),
		.kind       (kind_q),
		.address    (addr_q),
		.pos_x      (pos_x_q),
		.pos_y      (pos_y_q),
		.own_x      (own_x_q),
		.own_y      (own_y_q),
		.now_ms     (now_q),
		.lifetime   (lifetime_q),
		.rd_data    (rd_data),
		.slot_valid (valid_q),
		.expire_en  (expire_en),
		.expire_idx (expire_idx),
		.sum        (sum),
		.match_idx  (match_idx),
		.free_idx   (free_idx)
	);

endmodule

// ===== hw/rtl/gnt_checker.sv =====
// Port-level checks of the greedy neighbor table, bound to the top level.
// Depends on gnt_pkg for result codes.
module gnt_checker import gnt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [2:0]        rsp_status,
	input logic [ADDR_W-1:0] rsp_next_hop
);

	// A waiting result holds still until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_next_hop))
		else $error("result changed while stalled");

	// Only one request is in flight: ready drops right after an acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// No result can appear in the cycle right after a request is accepted.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// The next hop is zero unless a hop was found.
	a_hop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_HOP) |-> rsp_next_hop == '0)
		else $error("next hop set without a hop result");

endmodule

bind greedy_neighbor_table gnt_checker u_gnt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_next_hop (rsp.next_hop)
);
